// ===== hdl/smx_pkg.sv =====
// Shared types, constants and opcodes for the stack machine execute unit.
package smx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W = 7;

    typedef enum logic [3:0] {
        OP_IN   = 4'd0,
        OP_OUT  = 4'd1,
        OP_DROP = 4'd2,
        OP_ADD  = 4'd3,
        OP_SUB  = 4'd4,
        OP_MOD  = 4'd5,
        OP_DIV  = 4'd6,
        OP_MUL  = 4'd7,
        OP_AND  = 4'd8,
        OP_OR   = 4'd9,
        OP_LIT  = 4'd10,
        OP_SWAP = 4'd11,
        OP_DUP  = 4'd12,
        OP_IFEQ = 4'd13,
        OP_IFLT = 4'd14,
        OP_JUMP = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_BADDUP    = 3'd4
    } t_status;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] argument;
        logic signed [31:0] in_value;
    } t_in;

    typedef struct packed {
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               branch_taken;
        logic signed [31:0] branch_target;
        logic [2:0]         status;
        logic [6:0]         stack_depth;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POPA_REQ,
        S_POPA,
        S_POPB,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_SWAP_RD,
        S_SWAP_WR,
        S_SWAP_LO,
        S_DUP_RD,
        S_DUP_WR,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;       // capture the input transaction
        logic       rd_top;     // read entry count-1
        logic       rd_next;    // read entry count-2
        logic       pop_a;      // pop into operand a
        logic       pop_b;      // pop into operand b
        logic       exec;       // compute combinational result and push
        logic       div_start;
        logic       div_step;
        logic       div_push;
        logic       mul_push;
        logic       swap_wr;    // write next entry into top slot
        logic       swap_lo;    // write old top into next slot
        logic       flag_few;   // flag too few entries
        logic       dup_init;
        logic       dup_rd;
        logic       dup_wr;
        logic       br_cmp;     // evaluate IFEQ/IFLT on popped operands
        logic       push_in;    // push in_value or literal
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic [3:0] func;
        logic       count_lt2;
        logic       dup_bad;
        logic       dup_last;
        logic       div_done;
    } t_sts;

endpackage

// ===== hdl/smx_datapath.sv =====
// Datapath: stack memory, count, operand registers, iterative divider, result.
module smx_datapath
    import smx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_result
);

    logic [31:0]      r_mem [STACK_DEPTH];
    logic [31:0]      r_rdata;
    logic [CNT_W-1:0] r_count;
    t_in              r_item;
    logic [31:0]      r_a;
    logic [31:0]      r_b;
    logic [2:0]       r_status;
    logic             r_out_valid;
    logic [31:0]      r_out_value;
    logic             r_taken;
    logic [CNT_W-1:0] r_dup_left;
    logic [CNT_W-1:0] r_dup_src;
    logic [31:0]      r_rem;
    logic [31:0]      r_quo;
    logic [31:0]      r_den;
    logic [5:0]       r_div_cnt;
    logic             r_nneg;
    logic             r_qneg;
    logic [31:0]      r_prod;

    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic             full;
    logic             empty;
    logic [31:0]      exec_val;
    logic [32:0]      div_trial;
    logic [31:0]      div_shift;
    logic [31:0]      num_mag;
    logic [31:0]      den_mag;
    logic             push_req;
    logic [31:0]      push_val;
    logic [2:0]       flag_code;
    logic             flag_req;
    logic [CNT_W-1:0] arg_clip;

    assign full  = (r_count == CNT_W'(STACK_DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        unique case (t_op'(r_item.func))
            OP_ADD:  exec_val = r_a + r_b;
            OP_SUB:  exec_val = r_b - r_a;
            OP_AND:  exec_val = r_a & r_b;
            default: exec_val = r_a | r_b;
        endcase
    end

    assign num_mag   = r_b[31] ? 32'd0 - r_b : r_b;
    assign den_mag   = r_a[31] ? 32'd0 - r_a : r_a;
    assign div_shift = {r_rem[30:0], r_quo[31]};
    assign div_trial = {1'b0, div_shift} - {1'b0, r_den};

    always_comb begin
        rd_addr = PTR_W'(r_count - CNT_W'(1));
        if (i_cmd.rd_next || i_cmd.pop_a) begin
            rd_addr = PTR_W'(r_count - CNT_W'(2));
        end else if (i_cmd.dup_rd) begin
            rd_addr = PTR_W'(r_dup_src);
        end
    end

    always_comb begin
        push_req = 1'b0;
        push_val = '0;
        if (i_cmd.push_in) begin
            push_req = 1'b1;
            push_val = (t_op'(r_item.func) == OP_IN) ? r_item.in_value : r_item.argument;
        end else if (i_cmd.exec) begin
            push_req = 1'b1;
            push_val = exec_val;
        end else if (i_cmd.div_push) begin
            push_req = 1'b1;
            if (r_a == '0) begin
                push_val = '0;
            end else if (t_op'(r_item.func) == OP_MOD) begin
                push_val = r_nneg ? 32'd0 - r_rem : r_rem;
            end else begin
                push_val = r_qneg ? 32'd0 - r_quo : r_quo;
            end
        end else if (i_cmd.mul_push) begin
            push_req = 1'b1;
            push_val = r_prod;
        end else if (i_cmd.dup_wr) begin
            push_req = 1'b1;
            push_val = r_rdata;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = PTR_W'(r_count);
        wr_data = push_val;
        if (push_req && !full) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_wr) begin
            wr_en   = 1'b1;
            wr_addr = PTR_W'(r_count - CNT_W'(1));
            wr_data = r_rdata;
        end else if (i_cmd.swap_lo) begin
            wr_en   = 1'b1;
            wr_addr = PTR_W'(r_count - CNT_W'(2));
            wr_data = r_a;
        end
    end

    always_comb begin
        flag_req  = 1'b0;
        flag_code = ST_OK;
        if (i_cmd.flag_few) begin
            flag_req  = 1'b1;
            flag_code = ST_UNDERFLOW;
        end else if ((i_cmd.pop_a || i_cmd.pop_b) && empty) begin
            flag_req  = 1'b1;
            flag_code = ST_UNDERFLOW;
        end else if (i_cmd.div_start && r_a == '0 && t_op'(r_item.func) != OP_MUL) begin
            flag_req  = 1'b1;
            flag_code = ST_DIVZERO;
        end else if (push_req && full) begin
            flag_req  = 1'b1;
            flag_code = ST_OVERFLOW;
        end
    end

    assign arg_clip = (r_item.argument > $signed({1'b0, 32'(r_count)}))
                    ? r_count : CNT_W'(r_item.argument);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (push_req && !full) begin
            r_count <= r_count + CNT_W'(1);
        end else if ((i_cmd.pop_a || i_cmd.pop_b) && !empty) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item      <= i_item;
            r_status    <= ST_OK;
            r_out_valid <= (t_op'(i_item.func) == OP_OUT);
            r_out_value <= '0;
            r_taken     <= (t_op'(i_item.func) == OP_JUMP);
            r_a         <= '0;
            r_b         <= '0;
        end else begin
            if (flag_req && r_status == ST_OK) begin
                r_status <= flag_code;
            end
            if (i_cmd.pop_a) begin
                r_a <= empty ? 32'hFFFF_FFFF : r_rdata;
                if (t_op'(r_item.func) == OP_OUT) begin
                    r_out_value <= empty ? 32'hFFFF_FFFF : r_rdata;
                end
            end
            if (i_cmd.pop_b) begin
                r_b <= empty ? 32'hFFFF_FFFF : r_rdata;
            end
            if (i_cmd.rd_next) begin
                r_a <= r_rdata;
            end
            if (i_cmd.br_cmp) begin
                r_taken <= (t_op'(r_item.func) == OP_IFEQ) ? (r_a == r_b)
                         : ($signed(r_b) < $signed(r_a));
            end
        end
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= num_mag;
            r_den     <= den_mag;
            r_div_cnt <= '0;
            r_nneg    <= r_b[31];
            r_qneg    <= r_b[31] ^ r_a[31];
            r_prod    <= r_a * r_b;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 6'd1;
            if (!div_trial[32]) begin
                r_rem <= div_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= div_shift;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.dup_init) begin
            r_dup_left <= arg_clip;
            r_dup_src  <= r_count - arg_clip;
        end else if (i_cmd.dup_wr) begin
            r_dup_left <= r_dup_left - CNT_W'(1);
            r_dup_src  <= r_dup_src + CNT_W'(1);
        end
    end

    assign o_sts.func      = r_item.func;
    assign o_sts.count_lt2 = (r_count < CNT_W'(2));
    assign o_sts.dup_bad   = (r_item.argument <= 0);
    assign o_sts.dup_last  = (r_dup_left == '0);
    assign o_sts.div_done  = (r_div_cnt == 6'd32) || (r_a == '0);

    assign o_result.out_valid     = r_out_valid;
    assign o_result.out_value     = r_out_value;
    assign o_result.branch_taken  = r_taken;
    assign o_result.branch_target = r_taken ? r_item.argument : '0;
    assign o_result.status        = (t_op'(r_item.func) == OP_DUP && r_item.argument <= 0)
                                  ? ST_BADDUP : r_status;
    assign o_result.stack_depth   = DEPTH_W'(r_count);

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH)) else $error("stack count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_req && full) |=> $stable(r_count)) else $error("push on full stack");
    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_div_cnt < 6'd32) else $error("divider overrun");
`endif

endmodule

// ===== hdl/smx_control.sv =====
// Controller state machine sequencing one instruction through the datapath.
module smx_control
    import smx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_POPA_REQ;
                end
            end
            S_POPA_REQ: begin
                unique case (t_op'(i_sts.func))
                    OP_IN, OP_LIT: begin
                        o_cmd.push_in = 1'b1;
                        n_state       = S_DONE;
                    end
                    OP_JUMP: n_state = S_DONE;
                    OP_SWAP, OP_IFEQ, OP_IFLT: begin
                        if (i_sts.count_lt2) begin
                            o_cmd.flag_few = 1'b1;
                            n_state        = S_DONE;
                        end else if (t_op'(i_sts.func) == OP_SWAP) begin
                            n_state = S_SWAP_RD;
                        end else begin
                            n_state = S_POPA;
                        end
                    end
                    OP_DUP: begin
                        if (i_sts.dup_bad) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.dup_init = 1'b1;
                            n_state        = S_DUP_RD;
                        end
                    end
                    default: n_state = S_POPA;
                endcase
            end
            S_POPA: begin
                o_cmd.pop_a = 1'b1;
                if (t_op'(i_sts.func) == OP_OUT || t_op'(i_sts.func) == OP_DROP) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_POPB;
                end
            end
            S_POPB: begin
                o_cmd.pop_b = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                unique case (t_op'(i_sts.func))
                    OP_IFEQ, OP_IFLT: begin
                        o_cmd.br_cmp = 1'b1;
                        n_state      = S_DONE;
                    end
                    OP_DIV, OP_MOD: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                    OP_MUL: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_MUL;
                    end
                    default: begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_push = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul_push = 1'b1;
                n_state        = S_DONE;
            end
            S_SWAP_RD: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_SWAP_WR;
            end
            S_SWAP_WR: begin
                o_cmd.swap_wr = 1'b1;
                n_state       = S_SWAP_LO;
            end
            S_SWAP_LO: begin
                o_cmd.swap_lo = 1'b1;
                n_state       = S_DONE;
            end
            S_DUP_RD: begin
                if (i_sts.dup_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.dup_rd = 1'b1;
                    n_state      = S_DUP_WR;
                end
            end
            S_DUP_WR: begin
                o_cmd.dup_wr = 1'b1;
                n_state      = S_DUP_RD;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> r_state == S_DONE) else $error("result dropped");
    a_one_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.exec, o_cmd.push_in, o_cmd.div_push, o_cmd.mul_push, o_cmd.dup_wr}))
        else $error("multiple pushes");
`endif

endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit.
// One instruction transaction at a time: the unit takes a new instruction only after the
// previous result has been taken. IN, LIT, JUMP, a bad DUP count and a SWAP, IFEQ or IFLT
// on fewer than two entries finish at decode; OUT and DROP pop one entry; ADD, SUB, AND,
// OR, IFEQ and IFLT pop two; SWAP reads and rewrites the top two entries; MUL pops two and
// pushes the product; DIV and MOD pop two and run a radix-2 restoring divider, one quotient
// bit per cycle (no steps on a zero divisor); DUP copies k entries (up to 64), one read and
// one write per copy through the stack memory. The stack holds 64 entries.
module stack_machine_execute_unit
    import smx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    smx_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    smx_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_data),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_out_data)
    );

endmodule

// ===== verif/stack_machine_execute_unit_tb.sv =====
// Testbench for the stack machine execute unit: directed and random instruction streams.
`timescale 1ns / 1ps

module stack_machine_execute_unit_tb;
    import smx_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    stack_machine_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #6 i_clk = ~i_clk;

    logic [31:0] model_stack [STACK_DEPTH];
    int unsigned model_count;
    logic [2:0]  model_status;
    t_out        results_due [$];
    int          error_count = 0;
    bit          send_idle_en = 1'b1;
    bit          recv_idle_en = 1'b1;
    int          recv_hold_cycles = 0;
    int          quiet_cycles = 0;

    function automatic void flag_status(logic [2:0] code);
        if (model_status == ST_OK) model_status = code;
    endfunction

    function automatic logic [31:0] pop_model();
        if (model_count == 0) begin
            flag_status(ST_UNDERFLOW);
            return 32'hFFFF_FFFF;
        end
        model_count--;
        return model_stack[model_count];
    endfunction

    function automatic void push_model(logic [31:0] v);
        if (model_count >= STACK_DEPTH) begin
            flag_status(ST_OVERFLOW);
            return;
        end
        model_stack[model_count] = v;
        model_count++;
    endfunction

    function automatic logic [31:0] signed_div(logic [31:0] num, logic [31:0] den, bit want_rem);
        logic [31:0] nm, dm, q, r;
        nm = num[31] ? -num : num;
        dm = den[31] ? -den : den;
        q = nm / dm;
        r = nm % dm;
        if (want_rem) return num[31] ? -r : r;
        return (num[31] != den[31]) ? -q : q;
    endfunction

    function automatic t_out execute_model(t_in item);
        t_out res;
        logic [31:0] a, b, t;
        int unsigned k, base;
        res = '0;
        model_status = ST_OK;
        case (t_op'(item.func))
            OP_IN:   push_model(item.in_value);
            OP_OUT: begin
                res.out_value = pop_model();
                res.out_valid = 1'b1;
            end
            OP_DROP: void'(pop_model());
            OP_LIT:  push_model(item.argument);
            OP_SWAP: begin
                if (model_count < 2) flag_status(ST_UNDERFLOW);
                else begin
                    t = model_stack[model_count-1];
                    model_stack[model_count-1] = model_stack[model_count-2];
                    model_stack[model_count-2] = t;
                end
            end
            OP_DUP: begin
                if (item.argument <= 0) flag_status(ST_BADDUP);
                else begin
                    k = (item.argument < model_count) ? item.argument : model_count;
                    base = model_count - k;
                    for (int i = 0; i < k; i++) push_model(model_stack[base+i]);
                end
            end
            OP_IFEQ, OP_IFLT: begin
                if (model_count < 2) flag_status(ST_UNDERFLOW);
                else begin
                    a = pop_model();
                    b = pop_model();
                    if (item.func == OP_IFEQ ? (a == b) : ($signed(b) < $signed(a))) begin
                        res.branch_taken = 1'b1;
                        res.branch_target = item.argument;
                    end
                end
            end
            OP_JUMP: begin
                res.branch_taken = 1'b1;
                res.branch_target = item.argument;
            end
            default: begin
                a = pop_model();
                b = pop_model();
                case (t_op'(item.func))
                    OP_ADD: t = a + b;
                    OP_SUB: t = b - a;
                    OP_MOD, OP_DIV: begin
                        if (a == 0) begin
                            flag_status(ST_DIVZERO);
                            t = 0;
                        end else begin
                            t = signed_div(b, a, item.func == OP_MOD);
                        end
                    end
                    OP_MUL: t = a * b;
                    OP_AND: t = a & b;
                    default: t = a | b;
                endcase
                push_model(t);
            end
        endcase
        res.status = model_status;
        res.stack_depth = model_count[6:0];
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_instr(t_op op, logic [31:0] arg, logic [31:0] inv);
        t_in item;
        bit  ready_seen;
        item = '{func: op, argument: arg, in_value: inv};
        if (send_idle_en) begin
            while ($urandom_range(0, 99) < 20) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(negedge i_clk);
            ready_seen = o_in_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        results_due.push_back(execute_model(item));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result transaction");
                error_count++;
            end else begin
                t_out exp_r;
                exp_r = results_due.pop_front();
                if (o_out_data.out_valid !== exp_r.out_valid) begin
                    $error("out_valid exp %0d got %0d", exp_r.out_valid, o_out_data.out_valid);
                    error_count++;
                end
                if (o_out_data.out_value !== exp_r.out_value) begin
                    $error("out_value exp %0d got %0d", exp_r.out_value, o_out_data.out_value);
                    error_count++;
                end
                if (o_out_data.branch_taken !== exp_r.branch_taken) begin
                    $error("branch_taken exp %0d got %0d", exp_r.branch_taken,
                           o_out_data.branch_taken);
                    error_count++;
                end
                if (o_out_data.branch_target !== exp_r.branch_target) begin
                    $error("branch_target exp %0d got %0d", exp_r.branch_target,
                           o_out_data.branch_target);
                    error_count++;
                end
                if (o_out_data.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.stack_depth !== exp_r.stack_depth) begin
                    $error("stack_depth exp %0d got %0d", exp_r.stack_depth,
                           o_out_data.stack_depth);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else if (recv_idle_en) begin
            i_out_ready <= ($urandom_range(0, 99) >= 20);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed();
        send_instr(OP_OUT, 0, 0);
        send_instr(OP_DROP, 0, 0);
        send_instr(OP_ADD, 0, 0);
        send_instr(OP_SWAP, 0, 0);
        send_instr(OP_IFEQ, 5, 0);
        send_instr(OP_IN, 0, 32'h8000_0000);
        send_instr(OP_LIT, 32'hFFFF_FFFF, 0);
        send_instr(OP_DIV, 0, 0);
        send_instr(OP_IN, 0, 32'h8000_0000);
        send_instr(OP_LIT, 32'hFFFF_FFFF, 0);
        send_instr(OP_MOD, 0, 0);
        send_instr(OP_LIT, 0, 0);
        send_instr(OP_DIV, 0, 0);
        send_instr(OP_LIT, 7, 0);
        send_instr(OP_SWAP, 0, 0);
        send_instr(OP_SUB, 0, 0);
        send_instr(OP_LIT, 32'h7FFF_FFFF, 0);
        send_instr(OP_MUL, 0, 0);
        send_instr(OP_DUP, 0, 0);
        send_instr(OP_DUP, 32'h8000_0000, 0);
        send_instr(OP_DUP, 32'h7FFF_FFFF, 0);
        send_instr(OP_IFLT, 32'h8000_0000, 0);
        send_instr(OP_JUMP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_instr(OP_AND, 0, 0);
        send_instr(OP_OR, 0, 0);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < 6; i++) send_instr(OP_DUP, 64, 0);
        send_instr(OP_IN, 0, 32'h1234_5678);
        send_instr(OP_ADD, 0, 0);
        for (int i = 0; i < 70; i++) send_instr(OP_DROP, 0, 0);
    endtask

    task automatic test_backpressure();
        recv_hold_cycles = 400;
        for (int i = 0; i < 8; i++) send_instr(OP_LIT, $urandom, 0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        t_op op;
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end
            if (i == n / 2) begin
                send_idle_en = 1'b1;
                recv_idle_en = 1'b1;
            end
            op = t_op'($urandom_range(0, 15));
            if (op == OP_DUP && $urandom_range(0, 3) != 0)
                send_instr(op, $urandom_range(1, 4), rand_word());
            else if ($urandom_range(0, 2) == 0)
                send_instr(OP_IN, rand_word(), rand_word());
            else
                send_instr(op, rand_word(), rand_word());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random(400);
        wait_drained();
        if (error_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/smx_pkg.sv
hdl/smx_datapath.sv
hdl/smx_control.sv
hdl/stack_machine_execute_unit.sv
verif/stack_machine_execute_unit_tb.sv
